/* rtl/core/mfd_pkg.sv */
// Shared types and constants for the motor feedback decode filter.
// No dependencies; the decoder and mfd_lane in rtl/core import this package.
package mfd_pkg;

  // Field widths of the feedback frame codes and of the datapath.
  localparam int unsigned POS_BITS   = 16;
  localparam int unsigned VEL_BITS   = 12;
  localparam int unsigned LIMIT_W    = 15;
  localparam int unsigned VAL_W      = 16;
  localparam int unsigned PROD_W     = 32;
  localparam int unsigned FACC_W     = 20;

  // Divisors 2^bits - 1 for the code spans.
  localparam logic [15:0] POS_SPAN   = 16'hFFFF;
  localparam logic [15:0] VEL_SPAN   = 16'h0FFF;

  // Smoothing weights in Q0.16: 0.3 for the new sample, 0.7 for the old output.
  localparam logic [15:0] ALPHA_Q16  = 16'd19661;
  localparam logic [15:0] BETA_Q16   = 16'd45875;

  // Register reset values.
  localparam logic [7:0]         MOTOR_ID_RST  = 8'd1;
  localparam logic [LIMIT_W-1:0] POS_LIM_RST   = 15'd3200;
  localparam logic [LIMIT_W-1:0] VEL_LIM_RST   = 15'd11520;
  localparam logic [LIMIT_W-1:0] TRQ_LIM_RST   = 15'd13824;

  localparam logic ACT_FRAME = 1'b0;
  localparam logic ACT_TICK  = 1'b1;

  typedef enum logic [1:0] {
    CFG_MOTOR_ID  = 2'd0,
    CFG_POS_LIM   = 2'd1,
    CFG_VEL_LIM   = 2'd2,
    CFG_TRQ_LIM   = 2'd3
  } cfg_idx_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MUL,
    ST_DIV,
    ST_PREP,
    ST_FILT,
    ST_COMMIT,
    ST_DONE
  } state_t;

  // Per-cycle commands from the sequencer to the three value lanes.
  typedef struct packed {
    logic load;
    logic mul_step;
    logic div_step;
    logic prep;
    logic filt_step;
    logic filt_last;
    logic commit;
    logic first;
  } lane_ctl_t;

endpackage

/* rtl/core/mfd_ifs.sv */
// Valid/ready channel interfaces for the feedback frame input and the decoded result.
// Does not import mfd_pkg; its field widths are written out as literals.
interface mfd_in_if;
  logic       valid;
  logic       ready;
  logic       action;
  logic [7:0] rx_id;
  logic [7:0] rx_byte1;
  logic [7:0] rx_byte2;
  logic [7:0] rx_byte3;
  logic [7:0] rx_byte4;
  logic [7:0] rx_byte5;

  modport source (output valid, action, rx_id, rx_byte1, rx_byte2, rx_byte3,
                  rx_byte4, rx_byte5, input ready);
  modport sink   (input valid, action, rx_id, rx_byte1, rx_byte2, rx_byte3,
                  rx_byte4, rx_byte5, output ready);
endinterface

interface mfd_out_if;
  logic               valid;
  logic               ready;
  logic signed [15:0] angle_now;
  logic signed [15:0] omega_now;
  logic signed [15:0] torque_now;
  logic               online;
  logic               send_enable;
  logic               accepted;

  modport source (output valid, angle_now, omega_now, torque_now, online,
                  send_enable, accepted, input ready);
  modport sink   (input valid, angle_now, omega_now, torque_now, online,
                  send_enable, accepted, output ready);
endinterface

/* rtl/core/mit_feedback_decode_filter.sv */
// Motor feedback frame decoder with per-value low-pass filters and link watchdog.
// A matching frame runs through the multiply, divide, prep, filter and commit states;
// the first frame after reset skips the filter pass, and ticks and frames with another
// ID go straight to the done state. One item at a time: a new beat is taken only once
// the result is loaded. Multiply, divide and filter are bit-serial. Reset (synchronous,
// rst_n low) clears filters, link flags and result valid and loads register defaults.
module mit_feedback_decode_filter
  import mfd_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  mfd_in_if.sink               in_chan,
  mfd_out_if.source            out_chan,
  input  logic                 cfg_we,
  input  cfg_idx_t             cfg_idx,
  input  logic [LIMIT_W-1:0]   cfg_wdata
);

  state_t                st_r, st_nxt;
  logic [4:0]            cnt_r, cnt_nxt;
  logic [7:0]            motor_id_r;
  logic [LIMIT_W-1:0]    pos_lim_r, vel_lim_r, trq_lim_r;
  logic                  any_seen_r, since_tick_r, link_online_r;
  logic                  first_r, se_r, acc_flag_r;
  logic                  out_valid_r;
  logic signed [15:0]    out_angle_r, out_omega_r, out_torque_r;
  logic                  out_online_r, out_se_r, out_acc_r;

  logic                  in_beat, is_frame, id_match, out_load;
  lane_ctl_t             ctl;
  logic [POS_BITS-1:0]   pos_raw, vel_raw, trq_raw;
  logic signed [VAL_W-1:0] angle_f, omega_f, torque_f;

  assign in_chan.ready = (st_r == ST_IDLE);
  assign in_beat       = in_chan.valid && in_chan.ready;
  assign is_frame      = (in_chan.action == ACT_FRAME);
  assign id_match      = (in_chan.rx_id == motor_id_r);
  assign out_load      = (st_r == ST_DONE) && (!out_valid_r || out_chan.ready);

  assign pos_raw = {in_chan.rx_byte1, in_chan.rx_byte2};
  assign vel_raw = {4'd0, in_chan.rx_byte3, in_chan.rx_byte4[7:4]};
  assign trq_raw = {4'd0, in_chan.rx_byte4[3:0], in_chan.rx_byte5};

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      motor_id_r <= MOTOR_ID_RST;
      pos_lim_r  <= POS_LIM_RST;
      vel_lim_r  <= VEL_LIM_RST;
      trq_lim_r  <= TRQ_LIM_RST;
    end else if (cfg_we) begin
      unique case (cfg_idx)
        CFG_MOTOR_ID: motor_id_r <= cfg_wdata[7:0];
        CFG_POS_LIM:  pos_lim_r  <= cfg_wdata;
        CFG_VEL_LIM:  vel_lim_r  <= cfg_wdata;
        CFG_TRQ_LIM:  trq_lim_r  <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // Next state.
  always_comb begin
    st_nxt = st_r;
    unique case (st_r)
      ST_IDLE:   if (in_beat) st_nxt = (is_frame && id_match) ? ST_MUL : ST_DONE;
      ST_MUL:    if (cnt_r == 5'd15) st_nxt = ST_DIV;
      ST_DIV:    if (cnt_r == 5'd31) st_nxt = ST_PREP;
      ST_PREP:   st_nxt = first_r ? ST_COMMIT : ST_FILT;
      ST_FILT:   if (cnt_r == 5'd15) st_nxt = ST_COMMIT;
      ST_COMMIT: st_nxt = ST_DONE;
      ST_DONE:   if (out_load) st_nxt = ST_IDLE;
      default:   st_nxt = ST_IDLE;
    endcase
    cnt_nxt = (st_nxt != st_r) ? 5'd0 : 5'(cnt_r + 5'd1);
  end

  // Lane commands.
  always_comb begin
    ctl           = '0;
    ctl.first     = first_r;
    unique case (st_r)
      ST_IDLE:   ctl.load      = in_beat;
      ST_MUL:    ctl.mul_step  = 1'b1;
      ST_DIV:    ctl.div_step  = 1'b1;
      ST_PREP:   ctl.prep      = 1'b1;
      ST_FILT: begin
        ctl.filt_step = 1'b1;
        ctl.filt_last = (cnt_r == 5'd15);
      end
      ST_COMMIT: ctl.commit    = 1'b1;
      ST_DONE:   ;
      default:   ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r  <= ST_IDLE;
      cnt_r <= '0;
    end else begin
      st_r  <= st_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  // Link flags and per-item flags, all settled at the input beat.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      any_seen_r    <= 1'b0;
      since_tick_r  <= 1'b0;
      link_online_r <= 1'b0;
      first_r       <= 1'b0;
      se_r          <= 1'b0;
      acc_flag_r    <= 1'b0;
    end else if (in_beat) begin
      if (is_frame) begin
        any_seen_r   <= 1'b1;
        since_tick_r <= 1'b1;
        first_r      <= !any_seen_r;
        se_r         <= 1'b0;
        acc_flag_r   <= id_match;
      end else begin
        link_online_r <= since_tick_r;
        se_r          <= !since_tick_r;
        since_tick_r  <= 1'b0;
        acc_flag_r    <= 1'b0;
      end
    end
  end

  mfd_lane u_pos (
    .clk, .rst_n, .ctl,
    .raw   (pos_raw),
    .limit (pos_lim_r),
    .span  (POS_SPAN),
    .filt  (angle_f)
  );

  mfd_lane u_vel (
    .clk, .rst_n, .ctl,
    .raw   (vel_raw),
    .limit (vel_lim_r),
    .span  (VEL_SPAN),
    .filt  (omega_f)
  );

  mfd_lane u_trq (
    .clk, .rst_n, .ctl,
    .raw   (trq_raw),
    .limit (trq_lim_r),
    .span  (VEL_SPAN),
    .filt  (torque_f)
  );

  // Result register; the next beat is taken while a result waits here.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_load) begin
      out_valid_r <= 1'b1;
    end else if (out_chan.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_angle_r  <= angle_f;
      out_omega_r  <= omega_f;
      out_torque_r <= torque_f;
      out_online_r <= link_online_r;
      out_se_r     <= se_r;
      out_acc_r    <= acc_flag_r;
    end
  end

  assign out_chan.valid       = out_valid_r;
  assign out_chan.angle_now   = out_angle_r;
  assign out_chan.omega_now   = out_omega_r;
  assign out_chan.torque_now  = out_torque_r;
  assign out_chan.online      = out_online_r;
  assign out_chan.send_enable = out_se_r;
  assign out_chan.accepted    = out_acc_r;

endmodule

/* rtl/core/mfd_lane.sv */
// One value lane: bit-serial scale (multiply, divide by 2^bits-1) and low-pass filter.
// Depends on mfd_pkg for lane_ctl_t and the filter weights.
module mfd_lane
  import mfd_pkg::*;
(
  input  logic                      clk,
  input  logic                      rst_n,
  input  lane_ctl_t                 ctl,
  input  logic [POS_BITS-1:0]       raw,
  input  logic [LIMIT_W-1:0]        limit,
  input  logic [15:0]               span,
  output logic signed [VAL_W-1:0]   filt
);

  logic [PROD_W-1:0]       acc_r, acc_nxt;
  logic [15:0]             rem_r, rem_nxt;
  logic [VAL_W-1:0]        xs_r, xs_nxt;
  logic [VAL_W-1:0]        ys_r, ys_nxt;
  logic [FACC_W-1:0]       fa_r, fa_nxt;
  logic [VAL_W-1:0]        filt_r;

  logic [16:0]             trial;
  logic                    ge;
  logic [16:0]             pp;
  logic [FACC_W:0]         fa_ext, pp_ext, fsum;

  // Restoring division: one dividend bit enters the remainder per cycle,
  // and the quotient bit fills the vacated low end of the dividend register.
  assign trial = {rem_r, acc_r[PROD_W-1]};
  assign ge    = (trial >= {1'b0, span});

  assign pp     = ({1'b0, xs_r[0] ? ALPHA_Q16 : 16'd0}) +
                  ({1'b0, ys_r[0] ? BETA_Q16  : 16'd0});
  assign fa_ext = {fa_r[FACC_W-1], fa_r};
  assign pp_ext = {{(FACC_W-16){1'b0}}, pp};
  // The sign bit of each two's complement operand carries negative weight.
  assign fsum   = ctl.filt_last ? (fa_ext - pp_ext) : (fa_ext + pp_ext);

  always_comb begin
    acc_nxt = acc_r;
    rem_nxt = rem_r;
    xs_nxt  = xs_r;
    ys_nxt  = ys_r;
    fa_nxt  = fa_r;
    if (ctl.load) begin
      acc_nxt = '0;
      rem_nxt = '0;
      xs_nxt  = raw;
    end else if (ctl.mul_step) begin
      acc_nxt = {acc_r[PROD_W-2:0], 1'b0} +
                (xs_r[VAL_W-1] ? {{(PROD_W-LIMIT_W-1){1'b0}}, limit, 1'b0} : '0);
      xs_nxt  = {xs_r[VAL_W-2:0], 1'b0};
    end else if (ctl.div_step) begin
      acc_nxt = {acc_r[PROD_W-2:0], ge};
      rem_nxt = ge ? 16'(trial - {1'b0, span}) : trial[15:0];
    end else if (ctl.prep) begin
      // The quotient never exceeds twice the limit, so it fits 16 bits.
      xs_nxt  = acc_r[VAL_W-1:0] - {1'b0, limit};
      ys_nxt  = filt_r;
      fa_nxt  = '0;
    end else if (ctl.filt_step) begin
      fa_nxt  = fsum[FACC_W:1];
      xs_nxt  = {1'b0, xs_r[VAL_W-1:1]};
      ys_nxt  = {1'b0, ys_r[VAL_W-1:1]};
    end
  end

  always_ff @(posedge clk) begin
    acc_r <= acc_nxt;
    rem_r <= rem_nxt;
    xs_r  <= xs_nxt;
    ys_r  <= ys_nxt;
    fa_r  <= fa_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      filt_r <= '0;
    end else if (ctl.commit) begin
      filt_r <= ctl.first ? xs_r : fa_r[VAL_W-1:0];
    end
  end

  assign filt = filt_r;

endmodule

/* tb/sv/mfd_feedback_checker.sv */
// Passive checker for the motor feedback decode filter: watches both channels and the
// register port, predicts every result beat and compares it field by field.
// Depends on mfd_pkg and the channel interfaces in mfd_ifs.sv.
module mfd_feedback_checker
  import mfd_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  mfd_in_if                  in_mon,
  mfd_out_if                 out_mon,
  input  logic               cfg_we,
  input  cfg_idx_t           cfg_idx,
  input  logic [LIMIT_W-1:0] cfg_wdata,
  output int unsigned        n_wrong,
  output int unsigned        n_outstanding
);

  typedef struct packed {
    logic signed [15:0] angle;
    logic signed [15:0] omega;
    logic signed [15:0] torque;
    logic               online;
    logic               send_enable;
    logic               accepted;
  } feedback_t;

  feedback_t expected_feedback[$];

  // Shadow copies of the registers and of the filter and link state.
  logic [7:0]         id_sel;
  logic [LIMIT_W-1:0] lim_pos;
  logic [LIMIT_W-1:0] lim_vel;
  logic [LIMIT_W-1:0] lim_trq;
  logic signed [15:0] angle_q;
  logic signed [15:0] omega_q;
  logic signed [15:0] torque_q;
  logic               seen_any;
  logic               seen_since_tick;
  logic               link_up;
  int unsigned        wrong = 0;

  // floor(raw * 2 * limit / (2^bits - 1)) - limit, all in Q8.8.
  function automatic logic signed [15:0] code_to_q8(logic [15:0] raw,
                                                    logic [LIMIT_W-1:0] lim,
                                                    int unsigned bits);
    longint unsigned span;
    longint unsigned num;
    span = (64'd1 << bits) - 64'd1;
    num  = 64'(raw) * 64'd2 * 64'(lim);
    return 16'(longint'(num / span) - longint'(lim));
  endfunction

  // The arithmetic shift of a signed sum floors toward minus infinity.
  function automatic logic signed [15:0] lowpass(logic signed [15:0] x,
                                                 logic signed [15:0] y);
    longint acc;
    acc = longint'(ALPHA_Q16) * longint'(x) + longint'(BETA_Q16) * longint'(y);
    return 16'(acc >>> 16);
  endfunction

  function automatic feedback_t predict_feedback(logic action, logic [7:0] id,
                                                 logic [7:0] b1, logic [7:0] b2,
                                                 logic [7:0] b3, logic [7:0] b4,
                                                 logic [7:0] b5);
    feedback_t          r;
    logic signed [15:0] a;
    logic signed [15:0] w;
    logic signed [15:0] t;
    logic               first;
    r.send_enable = 1'b0;
    r.accepted    = 1'b0;
    if (action == ACT_FRAME) begin
      // Any frame counts as link activity, whatever its ID.
      first           = !seen_any;
      seen_any        = 1'b1;
      seen_since_tick = 1'b1;
      if (id == id_sel) begin
        a = code_to_q8({b1, b2}, lim_pos, POS_BITS);
        w = code_to_q8({4'd0, b3, b4[7:4]}, lim_vel, VEL_BITS);
        // The torque code has the same width as the velocity code.
        t = code_to_q8({4'd0, b4[3:0], b5}, lim_trq, VEL_BITS);
        if (first) begin
          angle_q  = a;
          omega_q  = w;
          torque_q = t;
        end else begin
          angle_q  = lowpass(a, angle_q);
          omega_q  = lowpass(w, omega_q);
          torque_q = lowpass(t, torque_q);
        end
        r.accepted = 1'b1;
      end
    end else begin
      r.send_enable   = !seen_since_tick;
      link_up         = seen_since_tick;
      seen_since_tick = 1'b0;
    end
    r.angle  = angle_q;
    r.omega  = omega_q;
    r.torque = torque_q;
    r.online = link_up;
    return r;
  endfunction

  task automatic check_field(input string name, input logic signed [15:0] want,
                             input logic signed [15:0] got);
    if (got !== want) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      wrong++;
    end
  endtask

  always @(posedge clk) begin
    feedback_t want;
    if (!rst_n) begin
      id_sel          = MOTOR_ID_RST;
      lim_pos         = POS_LIM_RST;
      lim_vel         = VEL_LIM_RST;
      lim_trq         = TRQ_LIM_RST;
      angle_q         = '0;
      omega_q         = '0;
      torque_q        = '0;
      seen_any        = 1'b0;
      seen_since_tick = 1'b0;
      link_up         = 1'b0;
      expected_feedback.delete();
    end else begin
      if (cfg_we) begin
        case (cfg_idx)
          CFG_MOTOR_ID: id_sel  = cfg_wdata[7:0];
          CFG_POS_LIM:  lim_pos = cfg_wdata;
          CFG_VEL_LIM:  lim_vel = cfg_wdata;
          CFG_TRQ_LIM:  lim_trq = cfg_wdata;
          default: ;
        endcase
      end
      if (out_mon.valid && out_mon.ready) begin
        if (expected_feedback.size() == 0) begin
          $error("result beat arrived with no expected result waiting");
          wrong++;
        end else begin
          want = expected_feedback.pop_front();
          check_field("angle_now", want.angle, out_mon.angle_now);
          check_field("omega_now", want.omega, out_mon.omega_now);
          check_field("torque_now", want.torque, out_mon.torque_now);
          check_field("online", want.online, out_mon.online);
          check_field("send_enable", want.send_enable, out_mon.send_enable);
          check_field("accepted", want.accepted, out_mon.accepted);
        end
      end
      if (in_mon.valid && in_mon.ready) begin
        expected_feedback.push_back(predict_feedback(in_mon.action, in_mon.rx_id,
                                                     in_mon.rx_byte1, in_mon.rx_byte2,
                                                     in_mon.rx_byte3, in_mon.rx_byte4,
                                                     in_mon.rx_byte5));
      end
    end
    n_wrong       <= wrong;
    n_outstanding <= expected_feedback.size();
  end

endmodule

/* tb/sv/mit_feedback_decode_filter_tb.sv */
// Top of the motor feedback decode filter testbench: clock, reset, register writes,
// frame and tick stimulus, random back pressure and the verdict.
// Depends on mfd_pkg, mfd_ifs.sv, the block itself and mfd_feedback_checker.
module mit_feedback_decode_filter_tb;
  import mfd_pkg::*;

  localparam int unsigned CYCLE_LIMIT    = 1_000_000;
  localparam int unsigned SQUEEZE_CYCLES = 400;
  localparam int unsigned SQUEEZE_AFTER  = 120;
  localparam int unsigned DRAIN_CYCLES   = 80;
  localparam int unsigned PHASE_ITEMS    = 160;
  localparam int unsigned N_PHASES       = 6;

  typedef struct packed {
    logic       action;
    logic [7:0] id;
    logic [7:0] b1;
    logic [7:0] b2;
    logic [7:0] b3;
    logic [7:0] b4;
    logic [7:0] b5;
  } fb_beat_t;

  logic               clk = 1'b0;
  logic               rst_n;
  logic               cfg_we;
  cfg_idx_t           cfg_idx;
  logic [LIMIT_W-1:0] cfg_wdata;
  int unsigned        n_wrong;
  int unsigned        n_outstanding;
  int unsigned        cycles = 0;
  int unsigned        beats_sent = 0;
  logic               calm = 1'b0;
  logic               squeeze_done = 1'b0;
  logic [7:0]         cur_id;

  mfd_in_if  in_chan ();
  mfd_out_if out_chan ();

  mit_feedback_decode_filter DUT (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_chan   (in_chan),
    .out_chan  (out_chan),
    .cfg_we    (cfg_we),
    .cfg_idx   (cfg_idx),
    .cfg_wdata (cfg_wdata)
  );

  mfd_feedback_checker u_feedback_chk (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_mon        (in_chan),
    .out_mon       (out_chan),
    .cfg_we        (cfg_we),
    .cfg_idx       (cfg_idx),
    .cfg_wdata     (cfg_wdata),
    .n_wrong       (n_wrong),
    .n_outstanding (n_outstanding)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("** mit_feedback_decode_filter: FAILED **");
      $finish;
    end
  end

  // Mostly short gaps, a few long ones; none at all while calm is set.
  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (calm || r < 50) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  function automatic logic [7:0] rand_byte();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 8) return 8'h00;
    if (r < 16) return 8'hFF;
    return 8'($urandom_range(0, 255));
  endfunction

  function automatic logic [LIMIT_W-1:0] rand_limit();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 15) return 15'd1;
    if (r < 30) return 15'h7FFF;
    return 15'($urandom_range(1, 32767));
  endfunction

  function automatic fb_beat_t frame_beat(logic [7:0] id, logic [15:0] pos,
                                          logic [11:0] vel, logic [11:0] trq);
    fb_beat_t b;
    b.action = ACT_FRAME;
    b.id     = id;
    b.b1     = pos[15:8];
    b.b2     = pos[7:0];
    b.b3     = vel[11:4];
    b.b4     = {vel[3:0], trq[11:8]};
    b.b5     = trq[7:0];
    return b;
  endfunction

  function automatic fb_beat_t rand_frame(logic [7:0] id);
    fb_beat_t b;
    b.action = ACT_FRAME;
    b.id     = id;
    b.b1     = rand_byte();
    b.b2     = rand_byte();
    b.b3     = rand_byte();
    b.b4     = rand_byte();
    b.b5     = rand_byte();
    return b;
  endfunction

  // The payload of a tick is don't-care, so it carries random bytes.
  function automatic fb_beat_t tick_beat();
    fb_beat_t b;
    b        = rand_frame(8'($urandom_range(0, 255)));
    b.action = ACT_TICK;
    return b;
  endfunction

  task automatic send_beat(input fb_beat_t b);
    int unsigned gap;
    gap = pick_gap();
    if (gap != 0) begin
      in_chan.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_chan.valid <= 1'b1;
    {in_chan.action, in_chan.rx_id, in_chan.rx_byte1, in_chan.rx_byte2,
     in_chan.rx_byte3, in_chan.rx_byte4, in_chan.rx_byte5} <= b;
    do @(posedge clk); while (in_chan.ready !== 1'b1);
    beats_sent++;
  endtask

  // Drops valid and waits until every expected result has been taken.
  task automatic settle();
    in_chan.valid <= 1'b0;
    @(posedge clk);
    while (n_outstanding != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic write_regs(input logic [7:0] id, input logic [LIMIT_W-1:0] pos_lim,
                            input logic [LIMIT_W-1:0] vel_lim,
                            input logic [LIMIT_W-1:0] trq_lim);
    cfg_we    <= 1'b1;
    cfg_idx   <= CFG_MOTOR_ID;
    cfg_wdata <= LIMIT_W'(id);
    @(posedge clk);
    cfg_idx   <= CFG_POS_LIM;
    cfg_wdata <= pos_lim;
    @(posedge clk);
    cfg_idx   <= CFG_VEL_LIM;
    cfg_wdata <= vel_lim;
    @(posedge clk);
    cfg_idx   <= CFG_TRQ_LIM;
    cfg_wdata <= trq_lim;
    @(posedge clk);
    cfg_we    <= 1'b0;
    cur_id = id;
  endtask

  // Result side: random stalls, and once a long hold-off that backs the block up.
  initial begin
    int unsigned gap;
    out_chan.ready <= 1'b0;
    do @(posedge clk); while (!rst_n);
    forever begin
      if (!squeeze_done && beats_sent >= SQUEEZE_AFTER) begin
        out_chan.ready <= 1'b0;
        repeat (SQUEEZE_CYCLES) @(posedge clk);
        squeeze_done = 1'b1;
      end else begin
        gap = pick_gap();
        if (gap != 0) begin
          out_chan.ready <= 1'b0;
          repeat (gap) @(posedge clk);
        end
        out_chan.ready <= 1'b1;
        repeat ($urandom_range(1, 12)) @(posedge clk);
      end
    end
  end

  initial begin
    int unsigned r;
    rst_n         <= 1'b0;
    cfg_we        <= 1'b0;
    cfg_idx       <= CFG_MOTOR_ID;
    cfg_wdata     <= '0;
    in_chan.valid <= 1'b0;
    {in_chan.action, in_chan.rx_id, in_chan.rx_byte1, in_chan.rx_byte2,
     in_chan.rx_byte3, in_chan.rx_byte4, in_chan.rx_byte5} <= '0;
    cur_id = MOTOR_ID_RST;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;

    // Reset registers. A tick before any frame finds the link offline; the first
    // frame loads the filters, the next one is smoothed.
    send_beat(tick_beat());
    send_beat(frame_beat(cur_id, 16'h0000, 12'h000, 12'h000));
    send_beat(frame_beat(cur_id, 16'hFFFF, 12'hFFF, 12'hFFF));
    send_beat(frame_beat(8'h00, 16'h1234, 12'h567, 12'h89A));
    send_beat(tick_beat());
    send_beat(tick_beat());
    send_beat(frame_beat(8'hFF, 16'hFFFF, 12'hFFF, 12'hFFF));
    send_beat(frame_beat(cur_id, 16'h8000, 12'h800, 12'h7FF));
    send_beat(tick_beat());
    settle();

    // Smallest ID and limits.
    write_regs(8'h00, 15'd1, 15'd1, 15'd1);
    send_beat(frame_beat(cur_id, 16'h0000, 12'h000, 12'h000));
    send_beat(frame_beat(cur_id, 16'hFFFF, 12'hFFF, 12'hFFF));
    send_beat(frame_beat(cur_id, 16'hAAAA, 12'hAAA, 12'h555));
    send_beat(frame_beat(8'h01, 16'h0000, 12'h000, 12'h000));
    send_beat(tick_beat());
    send_beat(tick_beat());
    settle();

    // Largest ID and limits.
    write_regs(8'hFF, 15'h7FFF, 15'h7FFF, 15'h7FFF);
    send_beat(frame_beat(cur_id, 16'hFFFF, 12'hFFF, 12'hFFF));
    send_beat(frame_beat(cur_id, 16'h0000, 12'h000, 12'h000));
    send_beat(frame_beat(cur_id, 16'h5555, 12'h555, 12'hAAA));
    send_beat(frame_beat(8'hFE, 16'hFFFF, 12'hFFF, 12'hFFF));
    send_beat(tick_beat());
    settle();

    for (int ph = 0; ph < N_PHASES; ph++) begin
      calm = (ph == 1 || ph == 4);
      write_regs(8'($urandom_range(0, 255)), rand_limit(), rand_limit(), rand_limit());
      repeat (PHASE_ITEMS) begin
        r = $urandom_range(0, 99);
        if (r < 62) send_beat(rand_frame(cur_id));
        else if (r < 75) send_beat(rand_frame(8'($urandom_range(0, 255))));
        else send_beat(tick_beat());
      end
      settle();
    end
    calm = 1'b0;
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (n_outstanding != 0) $error("%0d expected results never arrived", n_outstanding);
    if (n_wrong == 0 && n_outstanding == 0) begin
      $display("** mit_feedback_decode_filter: PASSED **");
    end else begin
      $display("** mit_feedback_decode_filter: FAILED **");
    end
    $finish;
  end

endmodule
